/* src/ptba_pkg.sv */
`timescale 1ns / 1ps
// shared types and helpers for the peer traffic byte accounting block
// no dependencies; used by ptba_cell and peer_traffic_byte_accounting
package ptba_pkg;

  // direction codes of a result
  localparam logic [1:0] DIR_NONE     = 2'd0;
  localparam logic [1:0] DIR_INBOUND  = 2'd1;
  localparam logic [1:0] DIR_OUTBOUND = 2'd2;

  // reset value of the local host address, 192.168.1.109
  localparam logic [31:0] LOCAL_ADDR_RESET = 32'hC0A8_016D;

  // input transfer payload
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_addr;
    logic [15:0] total_len;
    logic [5:0]  minute;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [1:0]  direction;
    logic [6:0]  slot;
    logic [31:0] slot_bytes;
    logic        table_full;
    logic        report_valid;
    logic [31:0] report_rx_bytes;
    logic [31:0] report_tx_bytes;
  } out_item_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        active;
    logic        is_tx;
    logic [31:0] peer;
    logic [15:0] len;
    logic        found;
    logic [6:0]  slot;
    logic [31:0] count;
  } token_t;

  // saturating add of a packet length to a 32-bit counter
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {17'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

/* src/ptba_cell.sv */
`timescale 1ns / 1ps
// one slot of the receive and send peer tables plus one token stage
// depends on ptba_pkg for the token type and saturating add
module ptba_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  ptba_pkg::token_t tok_in,
  output ptba_pkg::token_t tok_out
);

  logic [31:0] rx_addr_r;
  logic [31:0] rx_bytes_r;
  logic [31:0] tx_addr_r;
  logic [31:0] tx_bytes_r;
  ptba_pkg::token_t tok_r;
  ptba_pkg::token_t tok_nxt;

  logic [31:0] sel_addr;
  logic [31:0] sel_bytes;
  logic [31:0] new_bytes;
  logic        hit;

  // pick the table this token works on and check for empty or matching slot
  assign sel_addr  = tok_in.is_tx ? tx_addr_r : rx_addr_r;
  assign sel_bytes = tok_in.is_tx ? tx_bytes_r : rx_bytes_r;
  assign new_bytes = ptba_pkg::sat_add(sel_bytes, tok_in.len);
  assign hit = tok_in.valid && tok_in.active && !tok_in.found &&
               ((sel_addr == 32'd0) || (sel_addr == tok_in.peer));

  // token update: claim here, or step the slot index on to the next cell
  always_comb begin
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.count = new_bytes;
    end else if (!tok_in.found) begin
      tok_nxt.slot = tok_in.slot + 7'd1;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_addr_r  <= '0;
      rx_bytes_r <= '0;
      tx_addr_r  <= '0;
      tx_bytes_r <= '0;
    end else if (hit) begin
      if (tok_in.is_tx) begin
        tx_addr_r  <= tok_in.peer;
        tx_bytes_r <= new_bytes;
      end else begin
        rx_addr_r  <= tok_in.peer;
        rx_bytes_r <= new_bytes;
      end
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

/* src/peer_traffic_byte_accounting.sv */
`timescale 1ns / 1ps
// top level of the peer traffic byte accounting block: chain of table cells
// depends on ptba_pkg and ptba_cell
//
// Usage: one IPv4 packet header per transfer on in_valid/in_ready/in_data
// (source, destination, total length, capture minute). Each packet gives
// exactly one result transfer on out_valid/out_ready/out_data with the
// direction, the peer slot and its byte count, the table-full flag and, when
// the minute changed, the closing minute's receive and send totals with this packet.
// The local host address is written through cfg_wr_en/cfg_wr_data while idle.
// A lookup token walks the row of PEER_SLOTS cells, one cell per cycle. One
// packet is in the chain at a time; in_ready comes back once the result has
// moved into the output register.
// Reset clears both peer tables, the minute totals and the last minute at
// once and loads the default local address; no sweep is needed.
// A stalled receiver holds out_data steady; the block still accepts one more
// packet and finishes its lookup, then waits with in_ready low.
module peer_traffic_byte_accounting #(
  parameter int PEER_SLOTS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptba_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);

  logic [31:0] local_addr_r;
  logic        busy_r;
  logic [31:0] rx_min_r;
  logic [31:0] tx_min_r;
  logic [5:0]  last_min_r;
  logic [31:0] rx_min_nxt;
  logic [31:0] tx_min_nxt;
  logic [1:0]  dir_r;
  logic        rep_valid_r;
  logic [31:0] rep_rx_r;
  logic [31:0] rep_tx_r;
  logic [31:0] rep_rx_nxt;
  logic [31:0] rep_tx_nxt;
  ptba_pkg::token_t head_r;
  ptba_pkg::token_t head_nxt;
  ptba_pkg::token_t done_r;
  logic        out_valid_r;
  ptba_pkg::out_item_t out_data_r;

  ptba_pkg::token_t tok [PEER_SLOTS+1];

  logic        in_fire;
  logic        inbound;
  logic        outbound;
  logic        min_change;
  logic [31:0] rx_sum;
  logic [31:0] tx_sum;
  logic        move_out;

  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  assign inbound  = (in_data.dst_addr == local_addr_r);
  assign outbound = (in_data.src_ip == local_addr_r);
  assign min_change = (in_data.minute != last_min_r);

  // minute totals including this packet, reported and cleared on a new minute
  always_comb begin
    rx_sum = inbound  ? ptba_pkg::sat_add(rx_min_r, in_data.total_len) : rx_min_r;
    tx_sum = outbound ? ptba_pkg::sat_add(tx_min_r, in_data.total_len) : tx_min_r;
    if (min_change) begin
      rep_rx_nxt = rx_sum;
      rep_tx_nxt = tx_sum;
      rx_min_nxt = '0;
      tx_min_nxt = '0;
    end else begin
      rep_rx_nxt = '0;
      rep_tx_nxt = '0;
      rx_min_nxt = rx_sum;
      tx_min_nxt = tx_sum;
    end
  end

  // lookup token for the head of the chain
  always_comb begin
    head_nxt        = '0;
    head_nxt.valid  = in_fire;
    head_nxt.active = inbound || outbound;
    head_nxt.is_tx  = !inbound;
    head_nxt.peer   = inbound ? in_data.src_ip : in_data.dst_addr;
    head_nxt.len    = in_data.total_len;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= ptba_pkg::LOCAL_ADDR_RESET;
    end else if (cfg_wr_en) begin
      local_addr_r <= cfg_wr_data;
    end
  end

  // minute state and per-packet report fields, taken at the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_min_r    <= '0;
      tx_min_r    <= '0;
      last_min_r  <= '0;
      dir_r       <= ptba_pkg::DIR_NONE;
      rep_valid_r <= 1'b0;
      rep_rx_r    <= '0;
      rep_tx_r    <= '0;
    end else if (in_fire) begin
      rx_min_r    <= rx_min_nxt;
      tx_min_r    <= tx_min_nxt;
      last_min_r  <= in_data.minute;
      dir_r       <= inbound ? ptba_pkg::DIR_INBOUND :
                     (outbound ? ptba_pkg::DIR_OUTBOUND : ptba_pkg::DIR_NONE);
      rep_valid_r <= min_change;
      rep_rx_r    <= rep_rx_nxt;
      rep_tx_r    <= rep_tx_nxt;
    end
  end

  // chain head register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  assign tok[0] = head_r;

  // row of table cells
  for (genvar i = 0; i < PEER_SLOTS; i++) begin : g_cell
    ptba_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // hold the token leaving the chain until the output register is free
  assign move_out = done_r.valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (tok[PEER_SLOTS].valid) begin
      done_r <= tok[PEER_SLOTS];
    end else if (move_out) begin
      done_r.valid <= 1'b0;
    end
  end

  // busy from input transfer until the result moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (move_out) begin
      busy_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      out_data_r.direction       <= dir_r;
      out_data_r.slot            <= done_r.found ? done_r.slot : 7'd0;
      out_data_r.slot_bytes      <= done_r.found ? done_r.count : 32'd0;
      out_data_r.table_full      <= done_r.active && !done_r.found;
      out_data_r.report_valid    <= rep_valid_r;
      out_data_r.report_rx_bytes <= rep_rx_r;
      out_data_r.report_tx_bytes <= rep_tx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
